// ----- hw/rtl/mpm_pkg.sv -----
// Package with shared constants and types of the matrix power unit.
package mpm_pkg;
  localparam int unsigned DimDefault = 5;
  localparam int unsigned ValW = 31;
  localparam int unsigned ExpW = 63;
  localparam int unsigned IdxW = 3;
  localparam logic [ValW-1:0] ModulusReset = 31'd1000000006;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_NEXT,
    ST_MUL_RD,
    ST_MUL_MAC,
    ST_MUL_RED,
    ST_MUL_WR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;
endpackage

// ----- hw/rtl/mpm_if.sv -----
// Valid/ready channel interfaces of the matrix power unit.
interface mpm_in_if import mpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [0:0]       command;
  logic [IdxW-1:0]  row;
  logic [IdxW-1:0]  col;
  logic [ValW-1:0]  value;
  logic [ExpW-1:0]  exponent;
  modport source (output valid, command, row, col, value, exponent, input ready);
  modport sink (input valid, command, row, col, value, exponent, output ready);
endinterface

interface mpm_out_if import mpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  out_row;
  logic [IdxW-1:0]  out_col;
  logic [ValW-1:0]  out_value;
  logic             last;
  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface mpm_cfg_if import mpm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/matrix_power_modulo.sv -----
// Top level of the matrix power unit: memories, sequencer and modular MAC.
//  channel  | direction | transaction carries
//  in_ch    | in        | command, row, col, value, exponent
//  out_ch   | out       | out_row, out_col, out_value, last
//  cfg_ch   | in        | data (modulus)
// After reset the base matrix is cleared entry by entry while input and configuration wait.
// A start sets the accumulator to the identity entry by entry, then runs one squaring per
// exponent bit plus one multiply per set bit, and then emits the result.
// Each multiply runs, for every entry, one MAC step per k (read, multiply-add and a 63-step
// remainder) and one write, then copies the result back with a read and a write per entry.
// Each result entry is read and then offered; a stalled output simply holds the sequencer.
module matrix_power_modulo import mpm_pkg::*; #(
  parameter int unsigned DIM = DimDefault
) (
  input logic clk,
  input logic rst,
  mpm_in_if.sink     in_ch,
  mpm_out_if.source  out_ch,
  mpm_cfg_if.sink    cfg_ch
);
  localparam int unsigned Cells = DIM * DIM;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned DW = 2 * ValW + 1;
  localparam logic [IdxW-1:0] Last = IdxW'(DIM - 1);
  localparam logic [5:0] RedLast = 6'(DW - 1);

  // Memories: base (B), accumulator (A) and scratch (P).
  logic [ValW-1:0] mem_b [Cells];
  logic [ValW-1:0] mem_a [Cells];
  logic [ValW-1:0] mem_p [Cells];

  logic [ValW-1:0] modulus;
  state_t state, state_next;
  logic [ExpW-1:0] exp_left;
  logic mul_acc;          // 1: A = A*B, 0: B = B*B
  logic acc_done;
  logic [IdxW-1:0] i, j, k;
  logic [IdxW-1:0] i_step, j_step;
  logic cell_last;
  logic [ValW-1:0] sum;
  logic [DW-1:0] dvd;
  logic [ValW-1:0] rem;
  logic [5:0] red_step;
  logic [ValW-1:0] rd_a, rd_bx, rd_by, rd_p;
  logic [AW-1:0] ax, ay, aij;
  logic [ValW-1:0] op_x;
  logic [2*ValW-1:0] prod;
  logic [DW-1:0] mac;
  logic [ValW:0] shifted;
  logic [ValW+1:0] diff;
  logic [ValW-1:0] rem_next;
  logic [ValW-1:0] ident;
  logic load_ok, start;

  function automatic logic [AW-1:0] addr(input logic [IdxW-1:0] r, input logic [IdxW-1:0] c);
    return AW'(r * DIM + c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) modulus <= ModulusReset;
    else if (cfg_ch.valid && cfg_ch.ready) modulus <= cfg_ch.data;
  end

  assign load_ok = in_ch.valid && in_ch.ready && (in_ch.command == CMD_LOAD)
                   && (in_ch.row < DIM) && (in_ch.col < DIM);
  assign start = in_ch.valid && in_ch.ready && (in_ch.command == CMD_START);

  assign cell_last = (i == Last) && (j == Last);
  assign aij = addr(i, j);
  assign ax = (state == ST_MUL_RD) ? addr(i, k) : aij;
  assign ay = addr(k, j);
  assign ident = (modulus < ValW'(2)) ? '0 : ValW'(1);

  // Row-major walk over the matrix, wrapping to the first entry after the last.
  always_comb begin
    if (j == Last) begin
      j_step = '0;
      i_step = (i == Last) ? '0 : i + 1'b1;
    end else begin
      j_step = j + 1'b1;
      i_step = i;
    end
  end

  always_ff @(posedge clk) begin
    rd_a  <= mem_a[ax];
    rd_bx <= mem_b[ax];
    rd_by <= mem_b[ay];
    rd_p  <= mem_p[aij];
    if (state == ST_MUL_WR) mem_p[aij] <= sum;
    if (state == ST_INIT) mem_a[aij] <= (i == j) ? ident : '0;
    else if (state == ST_COPY_WR && mul_acc) mem_a[aij] <= rd_p;
    if (state == ST_CLEAR) mem_b[aij] <= '0;
    else if (load_ok) mem_b[addr(in_ch.row, in_ch.col)] <= in_ch.value;
    else if (state == ST_COPY_WR && !mul_acc) mem_b[aij] <= rd_p;
    else if (state == ST_EMIT && out_ch.ready) mem_b[aij] <= rd_a;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (cell_last) state_next = ST_IDLE;
      ST_IDLE:    if (start) state_next = ST_INIT;
      ST_INIT:    if (cell_last) state_next = ST_NEXT;
      ST_NEXT:    state_next = (exp_left == '0) ? ST_EMIT_RD : ST_MUL_RD;
      ST_MUL_RD:  state_next = ST_MUL_MAC;
      ST_MUL_MAC: state_next = ST_MUL_RED;
      ST_MUL_RED: if (red_step == RedLast) begin
                    state_next = (k == Last) ? ST_MUL_WR : ST_MUL_RD;
                  end
      ST_MUL_WR:  state_next = cell_last ? ST_COPY_RD : ST_MUL_RD;
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: state_next = cell_last ? ST_NEXT : ST_COPY_RD;
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT:    if (out_ch.ready) state_next = cell_last ? ST_IDLE : ST_EMIT_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    cfg_ch.ready = (state == ST_IDLE);
    out_ch.valid = (state == ST_EMIT);
    out_ch.out_row = i;
    out_ch.out_col = j;
    out_ch.out_value = rd_a;
    out_ch.last = cell_last;
  end

  // Restoring remainder: one dividend bit per cycle over the 63-bit product sum.
  assign op_x = mul_acc ? rd_a : rd_bx;
  assign prod = op_x * rd_by;
  assign mac = {1'b0, prod} + {{(DW-ValW){1'b0}}, sum};
  assign shifted = {rem, dvd[DW-1]};
  assign diff = {1'b0, shifted} - {2'b00, modulus};
  assign rem_next = diff[ValW+1] ? shifted[ValW-1:0] : diff[ValW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      exp_left <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
      mul_acc <= 1'b0;
      acc_done <= 1'b0;
      sum <= '0;
      dvd <= '0;
      rem <= '0;
      red_step <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR, ST_INIT: begin
          i <= i_step;
          j <= j_step;
        end
        ST_IDLE: begin
          if (start) begin
            exp_left <= in_ch.exponent;
            acc_done <= 1'b0;
          end
        end
        ST_NEXT: begin
          k <= '0;
          sum <= '0;
          if (exp_left != '0) mul_acc <= exp_left[0] && !acc_done;
        end
        ST_MUL_RD: ;
        ST_MUL_MAC: begin
          dvd <= mac;
          rem <= '0;
          red_step <= '0;
        end
        ST_MUL_RED: begin
          rem <= rem_next;
          dvd <= {dvd[DW-2:0], 1'b0};
          red_step <= red_step + 1'b1;
          if (red_step == RedLast) begin
            sum <= (modulus < ValW'(2)) ? '0 : rem_next;
            if (k != Last) k <= k + 1'b1;
          end
        end
        ST_MUL_WR: begin
          sum <= '0;
          k <= '0;
          i <= i_step;
          j <= j_step;
        end
        ST_COPY_RD: ;
        ST_COPY_WR: begin
          i <= i_step;
          j <= j_step;
          // The multiply for a set bit comes first; the squaring then consumes the bit.
          if (cell_last) begin
            if (mul_acc) begin
              acc_done <= 1'b1;
            end else begin
              acc_done <= 1'b0;
              exp_left <= exp_left >> 1;
            end
          end
        end
        ST_EMIT_RD: ;
        ST_EMIT: begin
          if (out_ch.ready) begin
            i <= i_step;
            j <= j_step;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hw/rtl/mpm_checker.sv -----
// Port-level checker for the matrix power unit, bound to the top level.
module mpm_checker import mpm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [ValW-1:0] out_value
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value)) else $error("value not held");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid) else $error("output after last");
endmodule

bind matrix_power_modulo mpm_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_last(out_ch.last), .out_value(out_ch.out_value)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench of the matrix power unit with a built-in predictor.
module tb_top import mpm_pkg::*; ();

  localparam int unsigned DIM = DimDefault;
  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned HoldCycles = 40000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdleLimit = 5000000;
  localparam logic [ExpW-1:0] ExpAllOnes = {ExpW{1'b1}};
  localparam logic [ValW-1:0] ValAllOnes = {ValW{1'b1}};

  typedef logic [ValW-1:0] matrix_t [CELLS];

  typedef struct packed {
    logic [IdxW-1:0] out_row;
    logic [IdxW-1:0] out_col;
    logic [ValW-1:0] out_value;
    logic            last;
  } entry_t;

  logic clk = 1'b0;
  logic rst;

  mpm_in_if  in_ch ();
  mpm_out_if out_ch ();
  mpm_cfg_if cfg_ch ();

  matrix_power_modulo #(.DIM(DIM)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  logic [ValW-1:0] modulus_m;
  matrix_t         stored_m;
  entry_t          pending_q[$];

  int unsigned error_count;
  int unsigned loads_sent;
  int unsigned starts_sent;
  int unsigned entries_checked;
  int unsigned modulus_writes;
  bit          steady;
  int unsigned hold_req;

  function automatic logic [ValW-1:0] mod_reduce(logic [63:0] v);
    if (modulus_m < 2) begin
      return '0;
    end
    return ValW'(v % {33'd0, modulus_m});
  endfunction

  function automatic matrix_t mat_mul(matrix_t a, matrix_t b);
    matrix_t     prod;
    logic [63:0] acc;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          acc = acc + 64'(a[i*DIM+k]) * 64'(b[k*DIM+j]);
          acc = 64'(mod_reduce(acc));
        end
        prod[i*DIM+j] = acc[ValW-1:0];
      end
    end
    return prod;
  endfunction

  // Square-and-multiply from the identity; the result replaces the stored matrix.
  task automatic predict_power(logic [ExpW-1:0] exponent);
    matrix_t         acc_m;
    logic [ExpW-1:0] bits_left;
    entry_t          e;
    for (int i = 0; i < CELLS; i++) begin
      acc_m[i] = '0;
    end
    for (int i = 0; i < DIM; i++) begin
      acc_m[i*DIM+i] = mod_reduce(64'd1);
    end
    bits_left = exponent;
    while (bits_left != 0) begin
      if (bits_left[0]) begin
        acc_m = mat_mul(acc_m, stored_m);
      end
      stored_m = mat_mul(stored_m, stored_m);
      bits_left = bits_left >> 1;
    end
    stored_m = acc_m;
    for (int k = 0; k < CELLS; k++) begin
      e.out_row = IdxW'(k / DIM);
      e.out_col = IdxW'(k % DIM);
      e.out_value = stored_m[k];
      e.last = (k == CELLS - 1);
      pending_q = {pending_q, e};
    end
  endtask

  task automatic send_item(cmd_t cmd, logic [IdxW-1:0] r, logic [IdxW-1:0] c,
                           logic [ValW-1:0] v, logic [ExpW-1:0] exponent);
    while (!steady && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.row      <= r;
    in_ch.col      <= c;
    in_ch.value    <= v;
    in_ch.exponent <= exponent;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_LOAD) begin
      loads_sent++;
      if (r < DIM && c < DIM) begin
        stored_m[r*DIM+c] = v;
      end
    end else begin
      starts_sent++;
      predict_power(exponent);
    end
  endtask

  task automatic load_item(int r, int c, logic [ValW-1:0] v);
    send_item(CMD_LOAD, IdxW'(r), IdxW'(c), v, ExpW'($urandom()));
  endtask

  task automatic start_item(logic [ExpW-1:0] exponent);
    send_item(CMD_START, IdxW'($urandom()), IdxW'($urandom()), ValW'($urandom()), exponent);
  endtask

  // Lowers valid and waits until every predicted entry has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_modulus(logic [ValW-1:0] m);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    modulus_m = m;
    modulus_writes++;
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  task automatic test_load_corners();
    load_item(0, 0, ValAllOnes);
    load_item(DIM - 1, DIM - 1, '0);
    load_item(0, DIM - 1, 31'h2AAA_AAAA);
    load_item(DIM - 1, 0, 31'h5555_5555);
    // Indices outside the matrix must leave it untouched.
    load_item(7, 0, 31'd12345);
    load_item(0, 7, 31'd54321);
    load_item(DIM, DIM, 31'd777);
    start_item('0);
    start_item(63'd1);
    start_item(63'd2);
  endtask

  task automatic test_modulus_extremes();
    write_modulus(31'd2);
    for (int i = 0; i < DIM; i++) begin
      load_item(i, (i + 1) % DIM, ValAllOnes);
    end
    // Every exponent bit set, kept to modulus two to stay cheap to predict.
    start_item(ExpAllOnes);
    write_modulus(ValAllOnes);
    load_item(1, 1, ValAllOnes - 1);
    start_item(63'd3);
    write_modulus(31'd1);
    start_item('0);
    write_modulus(31'd0);
    start_item(63'd2);
    write_modulus(ModulusReset);
  endtask

  task automatic test_backpressure();
    int unsigned id;
    wait_drained();
    id = hold_req;
    hold_req = id + 1;
    start_item(63'd1);
    for (int i = 0; i < 6; i++) begin
      load_item($urandom_range(DIM - 1), $urandom_range(DIM - 1), ValW'($urandom()));
    end
    start_item(63'd2);
    wait_drained();
  endtask

  task automatic test_random_rounds();
    int unsigned n;
    for (int round = 0; round < 8; round++) begin
      steady = (round == 3);
      case ($urandom_range(5))
        0: write_modulus(31'd2);
        1: write_modulus(ValAllOnes);
        2: write_modulus(ValW'($urandom_range(3, 100)));
        default: write_modulus(ValW'($urandom()) | 31'd2);
      endcase
      n = $urandom_range(6, 11);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 15) begin
          load_item($urandom_range(7), $urandom_range(7), ValW'($urandom()));
        end else if ($urandom_range(1) == 0) begin
          load_item($urandom_range(DIM - 1), $urandom_range(DIM - 1), ValW'($urandom()));
        end else begin
          load_item($urandom_range(DIM - 1), $urandom_range(DIM - 1),
                    ValW'($urandom() % (modulus_m | 31'd1)));
        end
      end
      start_item(ExpW'($urandom_range(0, 6)));
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, long hold-offs on request, and the checker.
  int unsigned hold_seen;
  int unsigned hold_left;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  entry_t      want;
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      entries_checked++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected entry, row", out_ch.out_row, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.out_row !== want.out_row) begin
          report_mismatch("out_row", out_ch.out_row, want.out_row);
        end
        if (out_ch.out_col !== want.out_col) begin
          report_mismatch("out_col", out_ch.out_col, want.out_col);
        end
        if (out_ch.out_value !== want.out_value) begin
          report_mismatch("out_value", out_ch.out_value, want.out_value);
        end
        if (out_ch.last !== want.last) begin
          report_mismatch("last", out_ch.last, want.last);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_LOAD;
    in_ch.row      <= '0;
    in_ch.col      <= '0;
    in_ch.value    <= '0;
    in_ch.exponent <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    modulus_m = ModulusReset;
    for (int i = 0; i < CELLS; i++) begin
      stored_m[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_corners();
    test_modulus_extremes();
    test_backpressure();
    test_random_rounds();
    wait_drained();

    $display("Covered %0d loads and %0d power starts, %0d result entries checked,",
             loads_sent, starts_sent, entries_checked);
    $display("with %0d modulus writes including 0, 1, 2 and the largest value.",
             modulus_writes);
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d entries never arrived", error_count, pending_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- matrix_power_modulo.f -----
hw/rtl/mpm_pkg.sv
hw/rtl/mpm_if.sv
hw/rtl/matrix_power_modulo.sv
hw/rtl/mpm_checker.sv
verif/tb_top.sv
